FILE: rtl/xccfb_pkg.sv
// ---------------------------------------------------------------------------
// xccfb_pkg
// Shared types, constants and helpers for the XOR checked command frame builder.
// ---------------------------------------------------------------------------
package xccfb_pkg;

   localparam int ByteW  = 8;
   localparam int MusicW = 4;

   localparam logic [ByteW-1:0] HdrSync    = 8'hFD;
   localparam logic [ByteW-1:0] HdrLenHigh = 8'h00;
   localparam logic [ByteW-1:0] CmdSpeak   = 8'h01;
   localparam logic [ByteW-1:0] ParamBase  = 8'h01;
   localparam logic [ByteW-1:0] LenOffset  = 8'd3;

   // Byte position within a frame
   typedef enum logic [2:0] {
      PH_SYNC,
      PH_LENHI,
      PH_LEN,
      PH_CMD,
      PH_PARAM,
      PH_TEXT,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] text_byte;
      logic [ByteW-1:0] text_length;
   } item_type;

   typedef struct packed {
      logic [ByteW-1:0] frame_byte;
      logic             frame_end;
   } beat_type;

   // zero length counts as one byte
   function automatic logic [ByteW-1:0] eff_length(input logic [ByteW-1:0] len);
      eff_length = (len == '0) ? ByteW'(1) : len;
   endfunction

   function automatic logic [ByteW-1:0] param_byte(input logic [MusicW-1:0] music);
      param_byte = ParamBase | {music, {(ByteW-MusicW){1'b0}}};
   endfunction

endpackage

FILE: rtl/xor_checked_command_frame_builder_unit.sv
// ---------------------------------------------------------------------------
// xor_checked_command_frame_builder_unit
// Builds XOR checked command frames for a serial speech device from text beats.
// ---------------------------------------------------------------------------
//  channel | direction | ports                                   | beat
//  req     | in        | req_valid/ready, text_byte, text_length | one text byte
//  rsp     | out       | rsp_valid/ready, frame_byte, frame_end  | one frame byte
//  csr     | in        | csr_valid/ready, background_music       | music setting
//
//  Rate: one frame byte per cycle while rsp_ready is high and, but for the
//  checksum, a text beat waits. A middle text beat gives its byte, the first
//  beat of a frame the header and its byte, the last its byte and checksum.
//  Reset: synchronous, active high; clears the sequencer, frame counters,
//  music setting and the valid flags of both beat registers.
//  Stalls: a held input beat and a held result beat decouple req from rsp.
// ---------------------------------------------------------------------------
module xor_checked_command_frame_builder_unit (
   input  logic                           clock,
   input  logic                           reset,
   // text input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [xccfb_pkg::ByteW-1:0]    req_text_byte,
   input  logic [xccfb_pkg::ByteW-1:0]    req_text_length,
   // frame output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [xccfb_pkg::ByteW-1:0]    rsp_frame_byte,
   output logic                           rsp_frame_end,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [xccfb_pkg::MusicW-1:0]   csr_background_music
);
   import xccfb_pkg::*;

   item_type          req_item;
   item_type          item;
   logic              item_valid;
   logic              item_pop;
   beat_type          beat;
   logic              beat_valid;
   logic              beat_ready;
   beat_type          rsp_beat;
   logic [MusicW-1:0] music_ff, music_in;

   // config register is always writable; sampled live when a header is built
   assign csr_ready = 1'b1;
   assign music_in  = (csr_valid && csr_ready) ? csr_background_music : music_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         music_ff <= '0;
      end else begin
         music_ff <= music_in;
      end
   end

   assign req_item.text_byte   = req_text_byte;
   assign req_item.text_length = req_text_length;

   xccfb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // sequencer: one frame byte per accepted output beat
   xccfb_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .music      (music_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   xccfb_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_frame_byte = rsp_beat.frame_byte;
   assign rsp_frame_end  = rsp_beat.frame_end;

endmodule

FILE: rtl/xccfb_in_reg.sv
// ---------------------------------------------------------------------------
// xccfb_in_reg
// Input holding register: keeps one text beat until the framer consumes it.
// ---------------------------------------------------------------------------
module xccfb_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  xccfb_pkg::item_type req_item,
   output logic                item_valid,
   output xccfb_pkg::item_type item,
   input  logic                item_pop
);
   import xccfb_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_ready  = !valid_ff || item_pop;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = req_ready ? req_valid : valid_ff;
      item_in  = (req_valid && req_ready) ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: rtl/xccfb_framer.sv
// ---------------------------------------------------------------------------
// xccfb_framer
// Frame sequencer: header, text pass-through, XOR checksum.
// ---------------------------------------------------------------------------
module xccfb_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [xccfb_pkg::MusicW-1:0]    music,
   input  logic                            item_valid,
   input  xccfb_pkg::item_type             item,
   output logic                            item_pop,
   output logic                            beat_valid,
   output xccfb_pkg::beat_type             beat,
   input  logic                            beat_ready
);
   import xccfb_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] bytes_seen_ff, bytes_seen_in;
   logic [ByteW-1:0] running_xor_ff, running_xor_in;
   logic [ByteW-1:0] frame_total_ff, frame_total_in;
   logic [ByteW:0]   seen_next;
   logic             last_text;
   logic             emit;

   assign emit      = beat_valid && beat_ready;
   assign seen_next = {1'b0, bytes_seen_ff} + (ByteW+1)'(1);
   assign last_text = seen_next >= {1'b0, frame_total_ff};

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (emit) begin
         unique case (phase_ff)
            PH_SYNC:  phase_in = PH_LENHI;
            PH_LENHI: phase_in = PH_LEN;
            PH_LEN:   phase_in = PH_CMD;
            PH_CMD:   phase_in = PH_PARAM;
            PH_PARAM: phase_in = PH_TEXT;
            PH_TEXT:  phase_in = last_text ? PH_CHECK : PH_TEXT;
            PH_CHECK: phase_in = PH_SYNC;
            default:  phase_in = PH_SYNC;
         endcase
      end
   end

   // outputs
   always_comb begin
      beat_valid      = (phase_ff == PH_CHECK) || item_valid;
      item_pop        = emit && (phase_ff == PH_TEXT);
      beat.frame_end  = (phase_ff == PH_CHECK);
      unique case (phase_ff)
         PH_SYNC:  beat.frame_byte = HdrSync;
         PH_LENHI: beat.frame_byte = HdrLenHigh;
         PH_LEN:   beat.frame_byte = eff_length(item.text_length) + LenOffset;
         PH_CMD:   beat.frame_byte = CmdSpeak;
         PH_PARAM: beat.frame_byte = param_byte(music);
         PH_TEXT:  beat.frame_byte = item.text_byte;
         PH_CHECK: beat.frame_byte = running_xor_ff;
         default:  beat.frame_byte = '0;
      endcase
   end

   // frame bookkeeping
   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      running_xor_in = running_xor_ff;
      frame_total_in = frame_total_ff;
      if (emit) begin
         unique case (phase_ff)
            PH_SYNC: begin
               running_xor_in = HdrSync;
               frame_total_in = eff_length(item.text_length);
            end
            PH_TEXT: begin
               running_xor_in = running_xor_ff ^ beat.frame_byte;
               bytes_seen_in  = seen_next[ByteW-1:0];
            end
            PH_CHECK: begin
               running_xor_in = '0;
               bytes_seen_in  = '0;
            end
            default: begin
               running_xor_in = running_xor_ff ^ beat.frame_byte;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC;
         bytes_seen_ff  <= '0;
         running_xor_ff <= '0;
         frame_total_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         bytes_seen_ff  <= bytes_seen_in;
         running_xor_ff <= running_xor_in;
         frame_total_ff <= frame_total_in;
      end
   end

   a_text_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TEXT) |-> (bytes_seen_ff < frame_total_ff))
      else $error("text phase with frame already complete");

   a_total_set: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SYNC) |-> (frame_total_ff != '0))
      else $error("frame total not latched");

   a_sync_fresh: assert property (@(posedge clock) disable iff (reset)
      (emit && phase_ff == PH_SYNC) |-> (bytes_seen_ff == '0))
      else $error("header started mid-frame");

   a_check_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && phase_ff == PH_CHECK) |=> (running_xor_ff == '0 && phase_ff == PH_SYNC))
      else $error("checksum did not close frame");

endmodule

FILE: rtl/xccfb_out_reg.sv
// ---------------------------------------------------------------------------
// xccfb_out_reg
// Result register: holds one frame beat until the consumer takes it.
// ---------------------------------------------------------------------------
module xccfb_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_valid,
   output logic                beat_ready,
   input  xccfb_pkg::beat_type beat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xccfb_pkg::beat_type rsp_beat
);
   import xccfb_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;

   assign beat_ready = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_beat   = beat_ff;

   always_comb begin
      valid_in = beat_ready ? beat_valid : valid_ff;
      beat_in  = (beat_valid && beat_ready) ? beat : beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

endmodule

FILE: tb/sv/frame_byte_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_byte_checker
// Watches the text, frame and music channels of the frame builder. It keeps
// its own frame state, builds the expected frame beats for every accepted
// text beat, and compares each accepted frame beat in order.
// ---------------------------------------------------------------------------
module frame_byte_checker
   import xccfb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [ByteW-1:0]  req_text_byte,
   input  logic [ByteW-1:0]  req_text_length,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [ByteW-1:0]  rsp_frame_byte,
   input  logic              rsp_frame_end,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [MusicW-1:0] csr_background_music,
   output int                error_count,
   output int                beats_pending
);

   beat_type          expected_beats[$];
   logic [ByteW-1:0]  text_count;
   logic [ByteW-1:0]  frame_xor;
   logic [ByteW-1:0]  frame_len;
   logic [MusicW-1:0] music_sel;
   int                errors;

   initial begin
      error_count   = 0;
      beats_pending = 0;
      errors        = 0;
   end

   // queue one frame byte and fold it into the checksum
   task automatic add_byte(input logic [ByteW-1:0] value);
      expected_beats.push_back(beat_type'{frame_byte: value, frame_end: 1'b0});
      frame_xor = frame_xor ^ value;
   endtask

   task automatic build_frame_bytes(input logic [ByteW-1:0] text,
                                    input logic [ByteW-1:0] len);
      logic [ByteW-1:0] n;
      n = (len == '0) ? ByteW'(1) : len;
      if (text_count == '0) begin
         frame_len = n;
         frame_xor = '0;
         add_byte(HdrSync);
         add_byte(HdrLenHigh);
         add_byte(n + LenOffset);
         add_byte(CmdSpeak);
         add_byte(ParamBase | {music_sel, {(ByteW-MusicW){1'b0}}});
      end
      add_byte(text);
      text_count = text_count + 1'b1;
      if (text_count >= frame_len) begin
         expected_beats.push_back(beat_type'{frame_byte: frame_xor, frame_end: 1'b1});
         text_count = '0;
         frame_xor  = '0;
      end
   endtask

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         expected_beats.delete();
         text_count = '0;
         frame_xor  = '0;
         frame_len  = '0;
         music_sel  = '0;
      end else begin
         if (req_valid && req_ready)
            build_frame_bytes(req_text_byte, req_text_length);
         // music write lands after a text beat taken at the same edge
         if (csr_valid && csr_ready)
            music_sel = csr_background_music;
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected frame beat byte=%02h end=%0b",
                           $time, rsp_frame_byte, rsp_frame_end);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (want.frame_byte !== rsp_frame_byte || want.frame_end !== rsp_frame_end) begin
                  if (errors < 10)
                     $display("%0t: frame beat exp byte=%02h end=%0b got byte=%02h end=%0b",
                              $time, want.frame_byte, want.frame_end,
                              rsp_frame_byte, rsp_frame_end);
                  errors++;
               end
            end
         end
      end
      error_count   <= errors;
      beats_pending <= expected_beats.size();
   end

endmodule

FILE: tb/sv/xor_checked_command_frame_builder_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// xor_checked_command_frame_builder_unit_tb
// Drives text beats and music settings into the frame builder. A directed
// set covers one-byte and multi-byte frames at both music extremes, and a
// zero-length one at the top; random frames follow under three idling mixes.
// A side checker predicts every frame beat; this module gives the verdict.
// ---------------------------------------------------------------------------
module xor_checked_command_frame_builder_unit_tb;
   import xccfb_pkg::*;

   localparam int CycleLimit  = 200000;
   // idle this long before the verdict
   localparam int SettleCycles = 16;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [ByteW-1:0]  req_text_byte;
   logic [ByteW-1:0]  req_text_length;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [ByteW-1:0]  rsp_frame_byte;
   logic              rsp_frame_end;
   logic              csr_valid;
   logic              csr_ready;
   logic [MusicW-1:0] csr_background_music;

   int error_count;
   int beats_pending;
   int cycle_count  = 0;
   int send_gap_pct = 0;     // chance in 100 that the sender skips a cycle
   int recv_gap_pct = 0;     // chance in 100 that the receiver stalls a cycle
   int text_beats   = 0;

   xor_checked_command_frame_builder_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_text_length      (req_text_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_frame_end        (rsp_frame_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_background_music (csr_background_music)
   );

   frame_byte_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_text_length      (req_text_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_frame_end        (rsp_frame_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_background_music (csr_background_music),
      .error_count          (error_count),
      .beats_pending        (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: one ready decision per edge, so stalls land on header,
   // text and checksum beats alike.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One text beat. Random gaps go in front; valid then holds until taken.
   task automatic send_text(input logic [ByteW-1:0] text, input logic [ByteW-1:0] len);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= text;
      req_text_length <= len;
      do @(posedge clock); while (!req_ready);
      text_beats++;
   endtask

   // Stop sending and wait for every predicted frame beat to come out.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
   endtask

   // Music write; only called with the block drained.
   task automatic write_music(input logic [MusicW-1:0] sel);
      csr_valid            <= 1'b1;
      csr_background_music <= sel;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Whole frame with random text. Only the first beat's length counts;
   // later beats carry junk lengths that the block must ignore.
   task automatic send_frame(input logic [ByteW-1:0] len);
      int n;
      n = (len == '0) ? 1 : int'(len);
      for (int i = 0; i < n; i++)
         send_text(ByteW'($urandom), (i == 0) ? len : ByteW'($urandom));
   endtask

   // Mostly short frames, some zero-length, a few mid-size.
   task automatic send_random_frames(input int beat_goal, input bit pause_midway);
      int          start;
      int          pick;
      logic [ByteW-1:0] len;
      bit          paused;
      start  = text_beats;
      paused = 1'b0;
      while (text_beats - start < beat_goal) begin
         pick = $urandom_range(99);
         if (pick < 8)
            len = '0;
         else if (pick < 88)
            len = ByteW'($urandom_range(6, 1));
         else
            len = ByteW'($urandom_range(24, 7));
         send_frame(len);
         if (pause_midway && !paused && text_beats - start >= beat_goal / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_text_byte        = '0;
      req_text_length      = '0;
      rsp_ready            = 1'b0;
      csr_valid            = 1'b0;
      csr_background_music = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: sender light gaps, receiver heavy stalls.
      send_gap_pct = 21;
      recv_gap_pct = 59;

      // directed: music at its top value
      write_music(4'hF);
      send_text(8'h00, 8'd1);            // one-byte frame, all-zero text
      send_text(8'hFF, 8'd0);            // zero length behaves as one
      send_text(8'h80, 8'd2);
      send_text(8'h01, 8'd0);            // length ignored past first beat
      send_text(8'h7F, 8'd3);
      send_text(8'hAA, 8'hFF);
      send_text(8'h55, 8'd1);
      send_text(8'hC3, 8'd4);
      send_text(8'h3C, 8'd4);
      send_text(8'hFF, 8'd4);
      send_text(8'hFF, 8'd4);            // checksum of repeated bytes
      drain();

      // directed: music at zero
      write_music(4'h0);
      send_text(8'h12, 8'd1);
      send_text(8'hFE, 8'd2);
      send_text(8'h01, 8'd7);
      drain();

      write_music(4'($urandom_range(15)));
      send_random_frames(30, 1'b1);      // includes a full drain midway
      drain();

      // Phase 2: roles swapped.
      send_gap_pct = 59;
      recv_gap_pct = 21;
      write_music(4'($urandom_range(15)));
      send_random_frames(30, 1'b0);
      drain();

      // Phase 3: no idling at all.
      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_music(4'($urandom_range(15)));
      send_random_frames(30, 1'b0);
      drain();

      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && beats_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
rtl/xccfb_pkg.sv
rtl/xccfb_in_reg.sv
rtl/xccfb_framer.sv
rtl/xccfb_out_reg.sv
rtl/xor_checked_command_frame_builder_unit.sv
tb/sv/frame_byte_checker.sv
tb/sv/xor_checked_command_frame_builder_unit_tb.sv
